// ===== hdl/bavg_pkg.sv =====
`default_nettype none

package bavg_pkg;

   // field widths
   localparam int ChanW    = 8;
   localparam int RowW     = 12;
   localparam int ColW     = 11;
   localparam int InBlkW   = 8;
   localparam int SumW     = 24;

   // register widths and limits
   localparam int FrameRowsW = 13;
   localparam int FrameColsW = 12;
   localparam int BlockSizeW = 9;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 13;

   localparam int MaxRows  = 4096;
   localparam int MaxCols  = 2048;
   localparam int MaxBlock = 256;
   localparam int AddrW    = $clog2(MaxCols);

   // block area and divider sizing
   localparam int AreaW     = 2 * BlockSizeW - 1;
   localparam int DivSteps  = ChanW + 1;
   localparam int DivW      = AreaW + ChanW;
   localparam int StepCntW  = $clog2(DivSteps);

   // register reset values
   localparam logic [FrameRowsW-1:0] FrameRowsReset = 13'd480;
   localparam logic [FrameColsW-1:0] FrameColsReset = 12'd640;
   localparam logic [BlockSizeW-1:0] BlockSizeReset = 9'd8;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegFrameRows = 2'd0;
   localparam logic [CsrIdxW-1:0] RegFrameCols = 2'd1;
   localparam logic [CsrIdxW-1:0] RegBlockSize = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic update;
      logic div_step;
      logic load_out;
   } bavg_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
   } bavg_sts_type;

endpackage

`default_nettype wire

// ===== hdl/bavg_ctrl.sv =====
`default_nettype none

module bavg_ctrl
   import bavg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire bavg_sts_type sts,
   output bavg_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_DIV,
      S_FINISH
   } state_type;

   state_type             state_ff;
   logic [StepCntW-1:0]   step_ff;
   logic                  rsp_valid_ff;
   logic                  out_free;

   // output register may be loaded when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.accept   = (state_ff == S_IDLE) && req_valid;
      cmd.update   = (state_ff == S_UPDATE);
      cmd.div_step = (state_ff == S_DIV);
      cmd.load_out = (state_ff == S_FINISH) && out_free;
   end

   // state, step count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               step_ff <= '0;
               if (sts.emit) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepCntW'(DivSteps - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bavg_dp.sv =====
`default_nettype none

module bavg_dp
   import bavg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bavg_cmd_type          cmd,
   output bavg_sts_type               sts,
   input  wire logic                  csr_write_en,
   input  wire logic [CsrIdxW-1:0]    csr_index,
   input  wire logic [CsrDataW-1:0]   csr_wdata,
   input  wire logic                  req_frame_start,
   input  wire logic [ChanW-1:0]      req_chan0,
   input  wire logic [ChanW-1:0]      req_chan1,
   input  wire logic [ChanW-1:0]      req_chan2,
   output logic [RowW-1:0]            rsp_block_row,
   output logic [ColW-1:0]            rsp_block_col,
   output logic [ChanW-1:0]           rsp_avg0,
   output logic [ChanW-1:0]           rsp_avg1,
   output logic [ChanW-1:0]           rsp_avg2
);

   // configuration registers
   logic [FrameRowsW-1:0] frame_rows_ff;
   logic [FrameColsW-1:0] frame_cols_ff;
   logic [BlockSizeW-1:0] block_size_ff;
   logic [FrameRowsW-1:0] rows_lim;
   logic [FrameColsW-1:0] cols_lim;
   logic [BlockSizeW-1:0] bs_lim;

   // position counters
   logic [RowW-1:0]   row_pos_ff,  row_pos_in,  row_eff;
   logic [ColW-1:0]   col_pos_ff,  col_pos_in,  col_eff;
   logic [InBlkW-1:0] rib_ff,      rib_in,      rib_eff;
   logic [InBlkW-1:0] cib_ff,      cib_in,      cib_eff;
   logic [RowW-1:0]   band_ff,     band_in,     band_eff;
   logic [AddrW-1:0]  bci_ff,      bci_in,      bci_eff;
   logic              col_wrap, row_wrap, cblk_wrap, rblk_wrap;

   // per-beat latches
   logic [ChanW-1:0]  c0_ff, c1_ff, c2_ff;
   logic              first_ff;
   logic              emit_ff;
   logic [AddrW-1:0]  idx_ff;
   logic [RowW-1:0]   orow_ff;
   logic [AreaW-1:0]  area_ff;
   logic [ColW-1:0]   ocol_ff;

   // sum memory, three channels side by side
   logic [3*SumW-1:0] sum_mem [MaxCols];
   logic [3*SumW-1:0] rd_ff;
   logic [SumW-1:0]   new0, new1, new2;

   // divider
   logic [DivW-1:0]   div_ff;
   logic [DivW-1:0]   rem0_ff, rem1_ff, rem2_ff;
   logic [DivSteps-1:0] q0_ff, q1_ff, q2_ff;
   logic              ge0, ge1, ge2;

   logic [ColW+BlockSizeW-1:0] col_prod;

   // output register
   logic [RowW-1:0]   out_row_ff;
   logic [ColW-1:0]   out_col_ff;
   logic [ChanW-1:0]  out_avg0_ff, out_avg1_ff, out_avg2_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= FrameRowsReset;
         frame_cols_ff <= FrameColsReset;
         block_size_ff <= BlockSizeReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            RegFrameRows: frame_rows_ff <= csr_wdata;
            RegFrameCols: frame_cols_ff <= csr_wdata[FrameColsW-1:0];
            RegBlockSize: block_size_ff <= csr_wdata[BlockSizeW-1:0];
            default: ;
         endcase
      end
   end

   // clamp registers to their working ranges, zero acts as one
   always_comb begin
      if (frame_rows_ff == '0) begin
         rows_lim = FrameRowsW'(1);
      end else if (frame_rows_ff > FrameRowsW'(MaxRows)) begin
         rows_lim = FrameRowsW'(MaxRows);
      end else begin
         rows_lim = frame_rows_ff;
      end
      if (frame_cols_ff == '0) begin
         cols_lim = FrameColsW'(1);
      end else if (frame_cols_ff > FrameColsW'(MaxCols)) begin
         cols_lim = FrameColsW'(MaxCols);
      end else begin
         cols_lim = frame_cols_ff;
      end
      if (block_size_ff == '0) begin
         bs_lim = BlockSizeW'(1);
      end else if (block_size_ff > BlockSizeW'(MaxBlock)) begin
         bs_lim = BlockSizeW'(MaxBlock);
      end else begin
         bs_lim = block_size_ff;
      end
   end

   // frame start zeroes the positions seen by this beat
   assign row_eff  = req_frame_start ? '0 : row_pos_ff;
   assign col_eff  = req_frame_start ? '0 : col_pos_ff;
   assign rib_eff  = req_frame_start ? '0 : rib_ff;
   assign cib_eff  = req_frame_start ? '0 : cib_ff;
   assign band_eff = req_frame_start ? '0 : band_ff;
   assign bci_eff  = req_frame_start ? '0 : bci_ff;

   assign col_wrap  = ({1'b0, col_eff} + FrameColsW'(1)) >= cols_lim;
   assign row_wrap  = ({1'b0, row_eff} + FrameRowsW'(1)) >= rows_lim;
   assign cblk_wrap = ({1'b0, cib_eff} + BlockSizeW'(1)) >= bs_lim;
   assign rblk_wrap = ({1'b0, rib_eff} + BlockSizeW'(1)) >= bs_lim;

   // next positions
   always_comb begin
      row_pos_in = row_eff;
      col_pos_in = col_eff + 1'b1;
      rib_in     = rib_eff;
      cib_in     = cib_eff + 1'b1;
      band_in    = band_eff;
      bci_in     = bci_eff;
      if (col_wrap) begin
         col_pos_in = '0;
         cib_in     = '0;
         bci_in     = '0;
         if (row_wrap) begin
            row_pos_in = '0;
            rib_in     = '0;
            band_in    = '0;
         end else begin
            row_pos_in = row_eff + 1'b1;
            if (rblk_wrap) begin
               rib_in  = '0;
               band_in = row_eff + 1'b1;
            end else begin
               rib_in  = rib_eff + 1'b1;
            end
         end
      end else if (cblk_wrap) begin
         cib_in = '0;
         bci_in = bci_eff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         rib_ff     <= '0;
         cib_ff     <= '0;
         band_ff    <= '0;
         bci_ff     <= '0;
      end else if (cmd.accept) begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
         rib_ff     <= rib_in;
         cib_ff     <= cib_in;
         band_ff    <= band_in;
         bci_ff     <= bci_in;
      end
   end

   // latch the beat and the block facts it sees
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (cmd.accept) begin
         emit_ff <= cblk_wrap && rblk_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         c0_ff    <= req_chan0;
         c1_ff    <= req_chan1;
         c2_ff    <= req_chan2;
         first_ff <= (rib_eff == '0) && (cib_eff == '0);
         idx_ff   <= bci_eff;
         orow_ff  <= band_eff;
         area_ff  <= AreaW'(bs_lim) * AreaW'(bs_lim);
      end
   end

   assign sts.emit = emit_ff;

   // sum memory read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= sum_mem[bci_eff];
      end
   end

   // first pixel of a block loads, others accumulate
   assign new0 = first_ff ? SumW'(c0_ff) : rd_ff[SumW-1:0] + SumW'(c0_ff);
   assign new1 = first_ff ? SumW'(c1_ff) : rd_ff[2*SumW-1:SumW] + SumW'(c1_ff);
   assign new2 = first_ff ? SumW'(c2_ff) : rd_ff[3*SumW-1:2*SumW] + SumW'(c2_ff);

   // sum memory write
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sum_mem[idx_ff] <= {new2, new1, new0};
      end
   end

   assign col_prod = idx_ff * bs_lim;

   // restoring divide by area, one quotient bit per step, top bit means saturate
   assign ge0 = rem0_ff >= div_ff;
   assign ge1 = rem1_ff >= div_ff;
   assign ge2 = rem2_ff >= div_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rem0_ff <= DivW'(new0);
         rem1_ff <= DivW'(new1);
         rem2_ff <= DivW'(new2);
         div_ff  <= {area_ff, {ChanW{1'b0}}};
         q0_ff   <= '0;
         q1_ff   <= '0;
         q2_ff   <= '0;
         ocol_ff <= col_prod[ColW-1:0];
      end else if (cmd.div_step) begin
         if (ge0) begin
            rem0_ff <= rem0_ff - div_ff;
         end
         if (ge1) begin
            rem1_ff <= rem1_ff - div_ff;
         end
         if (ge2) begin
            rem2_ff <= rem2_ff - div_ff;
         end
         q0_ff  <= {q0_ff[DivSteps-2:0], ge0};
         q1_ff  <= {q1_ff[DivSteps-2:0], ge1};
         q2_ff  <= {q2_ff[DivSteps-2:0], ge2};
         div_ff <= div_ff >> 1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_row_ff  <= orow_ff;
         out_col_ff  <= ocol_ff;
         out_avg0_ff <= q0_ff[DivSteps-1] ? '1 : q0_ff[ChanW-1:0];
         out_avg1_ff <= q1_ff[DivSteps-1] ? '1 : q1_ff[ChanW-1:0];
         out_avg2_ff <= q2_ff[DivSteps-1] ? '1 : q2_ff[ChanW-1:0];
      end
   end

   assign rsp_block_row = out_row_ff;
   assign rsp_block_col = out_col_ff;
   assign rsp_avg0      = out_avg0_ff;
   assign rsp_avg1      = out_avg1_ff;
   assign rsp_avg2      = out_avg2_ff;

endmodule

`default_nettype wire

// ===== hdl/block_average_downsampler_top.sv =====
// channel   direction   handshake              payload
// req       in          req_valid/req_ready    frame_start, chan0..chan2
// rsp       out         rsp_valid/rsp_ready    block_row, block_col, avg0..avg2
// csr       in          csr_write_en           csr_index, csr_wdata
//
// a pixel that closes no block goes through accept with sum memory read, then
// read-modify-write of the block column sums
// a pixel that closes a block goes through both of these, 9 steps of the
// shared three-channel restoring divider, and a load into the output register
// the output register holds one result while the next pixel is taken; a second
// result waits in the divider until rsp_ready drains the first
// synchronous active-high reset restores register defaults and zeroes positions;
// sum memory is not cleared, the first pixel of each block overwrites its entry
`default_nettype none

module block_average_downsampler_top
   import bavg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_frame_start,
   input  wire logic [ChanW-1:0]      req_chan0,
   input  wire logic [ChanW-1:0]      req_chan1,
   input  wire logic [ChanW-1:0]      req_chan2,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [RowW-1:0]            rsp_block_row,
   output logic [ColW-1:0]            rsp_block_col,
   output logic [ChanW-1:0]           rsp_avg0,
   output logic [ChanW-1:0]           rsp_avg1,
   output logic [ChanW-1:0]           rsp_avg2,
   input  wire logic                  csr_write_en,
   input  wire logic [CsrIdxW-1:0]    csr_index,
   input  wire logic [CsrDataW-1:0]   csr_wdata
);

   bavg_cmd_type cmd;
   bavg_sts_type sts;

   // sequencing
   bavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, sums, divider and output register
   bavg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_frame_start (req_frame_start),
      .req_chan0       (req_chan0),
      .req_chan1       (req_chan1),
      .req_chan2       (req_chan2),
      .rsp_block_row   (rsp_block_row),
      .rsp_block_col   (rsp_block_col),
      .rsp_avg0        (rsp_avg0),
      .rsp_avg1        (rsp_avg1),
      .rsp_avg2        (rsp_avg2)
   );

endmodule

`default_nettype wire
